// File: hw/rtl/esp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esp_pkg: shared definitions for the encoder speed PID / PWM unit
// Sequencer steps, control struct, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package esp_pkg;

  // Shared multiplier operand and product widths.
  localparam int unsigned MulAW = 33;
  localparam int unsigned MulBW = 18;
  localparam int unsigned MulPW = MulAW + MulBW;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegPropGain  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIntegGain = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDerivGain = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIntegLim  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSamplePer = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCntScale  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPwmPeriod = 3'd6;
  localparam logic [CfgIdxW-1:0] RegRevDir    = 3'd7;

  // Sequencer steps of a control tick, in order.
  typedef enum logic [3:0] {
    StIdle,
    StSpeed,
    StError,
    StInc,
    StInteg,
    StPTerm,
    StITerm,
    StDTerm,
    StClamp,
    StCmp,
    StDone
  } step_e;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    step_e step;
    logic  accept;
    logic  finish;
  } ctrl_t;

endpackage

// File: hw/rtl/esp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esp_mul: shared signed multiplier with a registered product
// One 33 x 18 signed product per enabled cycle; the product holds otherwise.
// ----------------------------------------------------------------------------
module esp_mul (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [esp_pkg::MulAW-1:0]  a_i,
  input  logic signed [esp_pkg::MulBW-1:0]  b_i,
  output logic signed [esp_pkg::MulPW-1:0]  p_o
);

  logic signed [esp_pkg::MulPW-1:0] prod_q;

  // Product register, loaded only on steps that issue a multiply.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign p_o = prod_q;

endmodule

// File: hw/rtl/esp_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esp_seq: control tick sequencer
// Walks one accepted beat through the multiply, error, integral and clamp steps.
// ----------------------------------------------------------------------------
module esp_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_busy_i,
  output esp_pkg::ctrl_t ctrl_o
);

  esp_pkg::step_e step_q, step_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= esp_pkg::StIdle;
    end else begin
      step_q <= step_d;
    end
  end

  // Next step and strobes.
  always_comb begin
    step_d        = step_q;
    ctrl_o.step   = step_q;
    ctrl_o.accept = 1'b0;
    ctrl_o.finish = 1'b0;
    unique case (step_q)
      esp_pkg::StIdle: begin
        ctrl_o.accept = in_valid_i;
        if (in_valid_i) step_d = esp_pkg::StSpeed;
      end
      esp_pkg::StSpeed: step_d = esp_pkg::StError;
      esp_pkg::StError: step_d = esp_pkg::StInc;
      esp_pkg::StInc:   step_d = esp_pkg::StInteg;
      esp_pkg::StInteg: step_d = esp_pkg::StPTerm;
      esp_pkg::StPTerm: step_d = esp_pkg::StITerm;
      esp_pkg::StITerm: step_d = esp_pkg::StDTerm;
      esp_pkg::StDTerm: step_d = esp_pkg::StClamp;
      esp_pkg::StClamp: step_d = esp_pkg::StCmp;
      esp_pkg::StCmp:   step_d = esp_pkg::StDone;
      esp_pkg::StDone: begin
        // Wait here until the output register is free.
        ctrl_o.finish = !out_busy_i;
        if (!out_busy_i) step_d = esp_pkg::StIdle;
      end
      default: step_d = esp_pkg::StIdle;
    endcase
  end

endmodule

// File: hw/rtl/encoder_speed_pid_pwm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_speed_pid_pwm_unit: speed PID controller with PWM output
// Encoder count to speed, PID with clamped integral, PWM compare and direction.
// ----------------------------------------------------------------------------
// Each control tick is one input beat and gives one output beat. A beat is
// accepted only while the unit is idle, and the unit takes the next beat
// once it is back at idle after the result is ready. A tick makes six
// passes through the single shared 33 x 18 multiplier (speed, integral
// increment, three gain terms and the PWM scaling) plus the error, integral
// clamp and drive clamp steps. The result sits in an output register, so a
// new tick can be accepted while it waits; a tick that finishes while the
// previous result is still untaken waits in its last step. Configuration
// writes take effect on the next cycle.
// ----------------------------------------------------------------------------
module encoder_speed_pid_pwm_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [esp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [esp_pkg::CfgDataW-1:0]   cfg_data_i,
  // Input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [15:0]             encoder_count_i,
  input  logic                           negate_count_i,
  input  logic signed [15:0]             target_speed_i,
  // Output channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [15:0]                    pwm_compare_o,
  output logic                           direction_level_o,
  output logic signed [15:0]             measured_speed_o
);

  localparam logic signed [esp_pkg::MulPW-1:0] SpeedMax = 51'sd32767;
  localparam logic signed [esp_pkg::MulPW-1:0] SpeedMin = -51'sd32768;
  localparam logic signed [48:0]               UOne     = 49'sd1048576;

  // Configuration registers.
  logic signed [15:0] prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [30:0]        integ_lim_q;
  logic [15:0]        sample_per_q, cnt_scale_q, pwm_period_q;
  logic               rev_dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= '0;
      integ_gain_q <= '0;
      deriv_gain_q <= '0;
      integ_lim_q  <= 31'h7FFF_FFFF;
      sample_per_q <= '0;
      cnt_scale_q  <= '0;
      pwm_period_q <= '0;
      rev_dir_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        esp_pkg::RegPropGain:  prop_gain_q  <= cfg_data_i[15:0];
        esp_pkg::RegIntegGain: integ_gain_q <= cfg_data_i[15:0];
        esp_pkg::RegDerivGain: deriv_gain_q <= cfg_data_i[15:0];
        esp_pkg::RegIntegLim:  integ_lim_q  <= cfg_data_i[30:0];
        esp_pkg::RegSamplePer: sample_per_q <= cfg_data_i[15:0];
        esp_pkg::RegCntScale:  cnt_scale_q  <= cfg_data_i[15:0];
        esp_pkg::RegPwmPeriod: pwm_period_q <= cfg_data_i[15:0];
        esp_pkg::RegRevDir:    rev_dir_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  esp_pkg::ctrl_t ctrl;
  logic           out_valid_q;
  logic           out_busy;

  assign out_busy = out_valid_q && !out_ready_i;

  esp_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl)
  );

  assign in_ready_o = (ctrl.step == esp_pkg::StIdle);

  // Working registers of one tick.
  logic signed [16:0] count_q;
  logic signed [15:0] target_q;
  logic signed [15:0] speed_q;
  logic signed [16:0] error_q;
  logic signed [17:0] diff_q;
  logic signed [48:0] acc_q;
  logic [20:0]        mag_q;
  logic               u_pos_q, u_neg_q;

  // Controller state.
  logic signed [31:0] integ_q;
  logic signed [16:0] prev_err_q;
  logic               held_dir_q;

  // Shared multiplier and its operand select.
  logic signed [esp_pkg::MulAW-1:0] mul_a;
  logic signed [esp_pkg::MulBW-1:0] mul_b;
  logic signed [esp_pkg::MulPW-1:0] prod;
  logic                             mul_en;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (ctrl.step)
      esp_pkg::StSpeed: begin
        mul_a = {{16{count_q[16]}}, count_q};
        mul_b = {2'b00, cnt_scale_q};
      end
      esp_pkg::StInc: begin
        mul_a = {{16{error_q[16]}}, error_q};
        mul_b = {2'b00, sample_per_q};
      end
      esp_pkg::StPTerm: begin
        mul_a = {{16{error_q[16]}}, error_q};
        mul_b = {{2{prop_gain_q[15]}}, prop_gain_q};
      end
      esp_pkg::StITerm: begin
        mul_a = {integ_q[31], integ_q};
        mul_b = {{2{integ_gain_q[15]}}, integ_gain_q};
      end
      esp_pkg::StDTerm: begin
        mul_a = {{15{diff_q[17]}}, diff_q};
        mul_b = {{2{deriv_gain_q[15]}}, deriv_gain_q};
      end
      esp_pkg::StCmp: begin
        mul_a = {12'd0, mag_q};
        mul_b = {2'b00, pwm_period_q};
      end
      default: mul_en = 1'b0;
    endcase
  end

  esp_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Speed saturation, error and error difference.
  logic signed [16:0] cnt_ext;
  logic signed [15:0] speed_sat;
  logic signed [16:0] error_d;
  logic signed [17:0] diff_d;

  assign cnt_ext = {encoder_count_i[15], encoder_count_i};

  always_comb begin
    if (prod > SpeedMax) begin
      speed_sat = 16'sh7FFF;
    end else if (prod < SpeedMin) begin
      speed_sat = -16'sh8000;
    end else begin
      speed_sat = prod[15:0];
    end
  end

  assign error_d = {target_q[15], target_q} - {speed_sat[15], speed_sat};
  assign diff_d  = {error_d[16], error_d} - {prev_err_q[16], prev_err_q};

  // Integral update: the increment is the product floored by 2^16.
  logic signed [17:0] inc;
  logic signed [32:0] sum33, lim33, integ_d;

  assign inc   = prod[33:16];
  assign sum33 = {integ_q[31], integ_q} + {{15{inc[17]}}, inc};
  assign lim33 = {2'b00, integ_lim_q};

  always_comb begin
    if (sum33 > lim33) begin
      integ_d = lim33;
    end else if (sum33 < -lim33) begin
      integ_d = -lim33;
    end else begin
      integ_d = sum33;
    end
  end

  // Drive clamp to plus or minus one in Q.20 and its magnitude.
  logic signed [48:0] usum, uneg;
  logic [20:0]        mag_d;

  assign usum = acc_q + prod[48:0];
  assign uneg = -usum;

  always_comb begin
    if (usum > UOne || usum < -UOne) begin
      mag_d = UOne[20:0];
    end else if (usum < 0) begin
      mag_d = uneg[20:0];
    end else begin
      mag_d = usum[20:0];
    end
  end

  // Datapath registers stepped by the sequencer.
  always_ff @(posedge clk_i) begin
    unique case (ctrl.step)
      esp_pkg::StIdle: begin
        if (ctrl.accept) begin
          count_q  <= negate_count_i ? -cnt_ext : cnt_ext;
          target_q <= target_speed_i;
        end
      end
      esp_pkg::StError: begin
        speed_q <= speed_sat;
        error_q <= error_d;
        diff_q  <= diff_d;
      end
      esp_pkg::StITerm: acc_q <= prod[48:0];
      esp_pkg::StDTerm: acc_q <= acc_q + prod[48:0];
      esp_pkg::StClamp: begin
        mag_q   <= mag_d;
        u_pos_q <= (usum > 0);
        u_neg_q <= (usum < 0);
      end
      default: ;
    endcase
  end

  // Controller state across ticks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      prev_err_q <= '0;
      held_dir_q <= 1'b0;
    end else begin
      if (ctrl.step == esp_pkg::StError) prev_err_q <= error_d;
      if (ctrl.step == esp_pkg::StInteg) integ_q <= integ_d[31:0];
      if (ctrl.finish) begin
        if (u_pos_q) begin
          held_dir_q <= !rev_dir_q;
        end else if (u_neg_q) begin
          held_dir_q <= rev_dir_q;
        end
      end
    end
  end

  // Output register.
  logic [15:0]        out_cmp_q;
  logic signed [15:0] out_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      out_cmp_q   <= (u_pos_q || u_neg_q) ? prod[35:20] : 16'd0;
      out_speed_q <= speed_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pwm_compare_o     = out_cmp_q;
  assign direction_level_o = held_dir_q;
  assign measured_speed_o  = out_speed_q;

endmodule

// File: hw/rtl/esp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esp_checker: port-level checks for the encoder speed PID / PWM unit
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module esp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [esp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [esp_pkg::CfgDataW-1:0] cfg_data_i,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic signed [15:0]           encoder_count_i,
  input logic                         negate_count_i,
  input logic signed [15:0]           target_speed_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [15:0]                  pwm_compare_o,
  input logic                         direction_level_o,
  input logic signed [15:0]           measured_speed_o
);

  // An accepted beat keeps the unit busy for the following cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("esp_checker: input accepted while a tick was in progress");

  // A new result appears only as the unit returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("esp_checker: result raised while the unit was still busy");

  // A result taken mid-tick is followed by an empty output, unless the
  // running tick ends in the same cycle and the unit is back at idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !in_ready_o |=> !out_valid_o || in_ready_o)
    else $error("esp_checker: result repeated without a new tick");

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pwm_compare_o)
      && $stable(direction_level_o) && $stable(measured_speed_o))
    else $error("esp_checker: stalled result changed");

endmodule

bind encoder_speed_pid_pwm_unit esp_checker u_esp_checker (.*);
